FILE: rtl/tempo_map_time_to_beats_top_macros.svh
// Assertion helpers for the tempo map top level.
`ifndef TEMPO_MAP_TIME_TO_BEATS_TOP_MACROS_SVH
`define TEMPO_MAP_TIME_TO_BEATS_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TMB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tmb_pkg.sv
`default_nettype none
package tmb_pkg;

    localparam int TMB_ENTRIES_DEFAULT = 16;

    localparam int TIME_W  = 40;
    localparam int BPM_W   = 25;
    localparam int BEATS_W = 48;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;
    localparam int IN_W    = 112;
    localparam int OUT_W   = 80;

    // shared multiply/divide unit widths
    localparam int AR_W   = 108;
    localparam int MB_W   = 49;
    localparam int DV_W   = 63;
    localparam int P1_W   = 67;
    localparam int PROG_W = 17;

    localparam logic [BEATS_W-1:0] BEATS_MAX     = '1;
    localparam logic [BPM_W-1:0]   BASE_RESET    = 25'd7864320;
    // bpm * seconds to beats divides by 60 * 65536 = 15 * 2^18: drop 18 bits, then
    // multiply by ceil(2^52 / 15) and drop 52 bits, exact for any value below 2^48
    localparam int                 CONST_PRESHIFT = 18;
    localparam int                 RECIP_SHIFT    = 52;
    localparam logic [MB_W-1:0]    RECIP_15       = 49'd300239975158034;
    // 120 * 65536: ramp integral scale, multiplied by the segment length
    localparam logic [AR_W-1:0]    RAMP_SCALE    = 108'd7864320;

    localparam logic CFG_BASE_TEMPO  = 1'b0;
    localparam logic CFG_ENTRY_COUNT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_START,
        ST_T_FIRST,
        ST_T_SEG,
        ST_T_NXT,
        ST_T_PICK,
        ST_T_DIV,
        ST_T_M1,
        ST_T_M2,
        ST_B_START,
        ST_B_BASE,
        ST_B_CM,
        ST_B_CD,
        ST_B_SEG,
        ST_B_NXT,
        ST_B_EVAL,
        ST_B_RD,
        ST_B_R1,
        ST_B_R2,
        ST_B_R3,
        ST_B_ADV,
        ST_FIN
    } tmb_state_t;

    typedef enum logic {
        AR_MUL,
        AR_DIV
    } ar_op_t;

    typedef enum logic [3:0] {
        SRC_TDIV,
        SRC_TM1,
        SRC_TM2,
        SRC_BASE,
        SRC_CONST,
        SRC_RDVS,
        SRC_CSEG,
        SRC_R1,
        SRC_R2,
        SRC_R3,
        SRC_RDIV
    } ar_src_t;

    typedef enum logic [1:0] {
        TSEL_NONE,
        TSEL_BASE,
        TSEL_CUR,
        TSEL_RAMP
    } tempo_sel_t;

    typedef struct packed {
        logic              r;
        logic [BPM_W-1:0]  b;
        logic [TIME_W-1:0] t;
    } tmb_entry_t;

    typedef struct packed {
        logic       in_ready;
        logic       q_load;
        logic       rd_en;
        logic       rd_next;
        logic       idx_clr;
        logic       idx_inc;
        logic       cur_from_rd;
        logic       cur_from_nxt;
        logic       nxt_from_rd;
        logic       has_next_set;
        logic       has_next_clr;
        tempo_sel_t tempo_sel;
        logic       beats_clr;
        logic       beats_add;
        logic       p_load;
        logic       p1_load;
        logic       dvs_load;
        logic       ar_start;
        ar_src_t    ar_src;
        logic       out_load;
    } tmb_cmd_t;

    typedef struct packed {
        logic q_req;
        logic n_zero;
        logic q_lt_rd;
        logic rd_le_q;
        logic has_more;
        logic has_next;
        logic cur_ramp;
        logic q_le_cur;
        logic end_le_cur;
        logic q_le_seg_end;
        logic ar_busy;
        logic out_busy;
    } tmb_status_t;

endpackage
`default_nettype wire

FILE: rtl/tempo_map_time_to_beats_top.sv
// Tempo map: turns a time in seconds into the tempo at that time and the
// quarter-note beats elapsed since zero, from a table of up to TEMPO_ENTRIES
// tempo changes (constant or linearly ramped). A load beat writes one table
// entry. A query beat is worked by a controller and one shared shift-add
// multiplier / restoring divider that produces one bit per cycle: the tempo
// lookup walks the table and may take one divide plus two multiplies; the
// beat sum then takes one multiply and one multiply by the reciprocal of
// fifteen for the lead-in at base tempo and for each constant segment, and
// four multiplies and one divide for each ramped segment. The next beat is
// accepted while a result waits on the output.
`default_nettype none
`include "tempo_map_time_to_beats_top_macros.svh"
module tempo_map_time_to_beats_top
    import tmb_pkg::*;
#(
    parameter int TEMPO_ENTRIES = TMB_ENTRIES_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // entry_index[3:0], entry_time[43:4], entry_bpm[68:44], entry_ramp[69],
    // query_time[109:70]
    input  wire logic [IN_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // tempo_now[24:0], beats_elapsed[72:25]
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [BPM_W-1:0] cfg_data
);

    tmb_cmd_t    cmd;
    tmb_status_t st;

    tmb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    tmb_dp #(
        .TEMPO_ENTRIES (TEMPO_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_tready = cmd.in_ready;

    `TMB_ASSERT_SAME(a_idle_unit_free, s_tready, !st.ar_busy, "arith unit busy while idle")
    `TMB_ASSERT_NEXT(a_query_holds_off, s_tvalid && s_tready && s_tuser, !s_tready, "query beat did not stall input")
    `TMB_ASSERT_NEXT(a_result_shown, cmd.out_load, m_tvalid, "result load lost")

endmodule
`default_nettype wire

FILE: rtl/tmb_arith.sv
`default_nettype none
module tmb_arith
    import tmb_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ar_op_t          op,
    input  wire logic [AR_W-1:0] a,
    input  wire logic [MB_W-1:0] b,
    input  wire logic [DV_W-1:0] d,
    output logic                 busy,
    output logic [AR_W-1:0]      res
);

    localparam int CNT_W = $clog2(AR_W + 1);

    logic             busy_reg, busy_next;
    ar_op_t           op_reg, op_next;
    logic [AR_W-1:0]  a_reg, a_next;
    logic [MB_W-1:0]  b_reg, b_next;
    logic [DV_W-1:0]  d_reg, d_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AR_W-1:0]  res_reg, res_next;
    logic [DV_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        trial     = {rem_reg, a_reg[AR_W-1]};
        if (start)
        begin
            op_next   = op;
            a_next    = a;
            b_next    = b;
            d_next    = d;
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = CNT_W'(AR_W);
            busy_next = (op == AR_DIV) || (b != '0);
        end
        else if (busy_reg)
        begin
            case (op_reg)
                AR_MUL:
                begin
                    // shift-add, stop once the multiplier runs out of ones
                    if (b_reg[0])
                        res_next = res_reg + a_reg;
                    a_next    = a_reg << 1;
                    b_next    = b_reg >> 1;
                    busy_next = (b_reg[MB_W-1:1] != '0);
                end
                AR_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (trial >= {1'b0, d_reg})
                    begin
                        rem_next = DV_W'(trial - {1'b0, d_reg});
                        res_next = {res_reg[AR_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[DV_W-1:0];
                        res_next = {res_reg[AR_W-2:0], 1'b0};
                    end
                    a_next    = a_reg << 1;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    busy_next = (cnt_reg != CNT_W'(1));
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

FILE: rtl/tmb_dp.sv
`default_nettype none
module tmb_dp
    import tmb_pkg::*;
#(
    parameter int TEMPO_ENTRIES = TMB_ENTRIES_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tmb_cmd_t         cmd,
    output tmb_status_t           st,
    input  wire logic             s_tvalid,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [BPM_W-1:0] cfg_data
);

    localparam int AW = (TEMPO_ENTRIES > 1) ? $clog2(TEMPO_ENTRIES) : 1;
    localparam int CW = $clog2(TEMPO_ENTRIES + 1);
    localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

    // input beat fields
    logic [INDEX_W-1:0] in_index;
    tmb_entry_t         in_entry;
    logic [TIME_W-1:0]  in_query;

    assign in_index   = s_tdata[3:0];
    assign in_entry.t = s_tdata[43:4];
    assign in_entry.b = s_tdata[68:44];
    assign in_entry.r = s_tdata[69];
    assign in_query   = s_tdata[109:70];

    tmb_entry_t mem [TEMPO_ENTRIES];
    tmb_entry_t rd_reg;
    logic [IW-1:0] wr_idx;
    logic          wr_en;
    logic [AW-1:0] rd_addr;

    logic [BPM_W-1:0]   base_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [NW-1:0]      count_ext;
    logic [CW-1:0]      n;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_plus;
    logic               has_next_reg;
    logic [TIME_W-1:0]  q_reg;
    tmb_entry_t         cur_reg;
    tmb_entry_t         nxt_reg;
    logic [PROG_W-1:0]  p_reg;
    logic [P1_W-1:0]    p1_reg;
    logic [DV_W-1:0]    dvs_reg;
    logic [BPM_W-1:0]   tempo_reg;
    logic [BEATS_W-1:0] beats_reg;
    logic               out_valid_reg;
    logic [BPM_W-1:0]   out_tempo_reg;
    logic [BEATS_W-1:0] out_beats_reg;
    logic               recip_reg;

    logic [TIME_W-1:0]  seg_end;
    logic [TIME_W-1:0]  end_t;
    logic [TIME_W-1:0]  el;
    logic [TIME_W-1:0]  dur;
    logic [MB_W-1:0]    dur2_el;
    logic [TIME_W-1:0]  base_len;
    logic [PROG_W-1:0]  p_inv;
    logic [P1_W-1:0]    p1_sum;
    logic [AR_W-1:0]    ar_val;
    logic [BEATS_W:0]   beats_sum;
    logic               beats_sat;

    logic            ar_busy;
    logic [AR_W-1:0] ar_res;
    ar_op_t          ar_op;
    logic [AR_W-1:0] ar_a;
    logic [MB_W-1:0] ar_b;
    logic [DV_W-1:0] ar_d;

    // table write and registered read
    assign wr_idx   = IW'(in_index);
    assign wr_en    = s_tvalid && cmd.in_ready && !s_tuser
                      && ({1'b0, wr_idx} < (IW+1)'(TEMPO_ENTRIES));
    assign idx_plus = idx_reg + CW'(1);
    assign rd_addr  = cmd.rd_next ? idx_plus[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[AW-1:0]] <= in_entry;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    // clamp the entry count to the table depth
    assign count_ext = NW'(count_reg);
    assign n = (count_ext > NW'(TEMPO_ENTRIES)) ? CW'(TEMPO_ENTRIES) : count_ext[CW-1:0];

    // segment geometry
    assign seg_end  = has_next_reg ? nxt_reg.t : q_reg;
    assign end_t    = (q_reg < seg_end) ? q_reg : seg_end;
    assign el       = end_t - cur_reg.t;
    assign dur      = seg_end - cur_reg.t;
    assign dur2_el  = MB_W'({dur, 1'b0}) - MB_W'(el);
    assign base_len = ((n == '0) || (q_reg < rd_reg.t)) ? q_reg : rd_reg.t;
    assign p_inv    = 17'h10000 - ar_res[PROG_W-1:0];
    assign p1_sum   = p1_reg + ar_res[P1_W-1:0];

    // reciprocal product carries the quotient in its upper bits
    assign ar_val    = recip_reg ? (ar_res >> RECIP_SHIFT) : ar_res;
    assign beats_sum = {1'b0, beats_reg} + {1'b0, ar_val[BEATS_W-1:0]};
    assign beats_sat = (ar_val[AR_W-1:BEATS_W] != '0) || beats_sum[BEATS_W];

    always_comb
    begin
        ar_a  = '0;
        ar_b  = '0;
        ar_d  = '0;
        ar_op = (cmd.ar_src inside {SRC_TDIV, SRC_RDIV}) ? AR_DIV : AR_MUL;
        case (cmd.ar_src)
            SRC_TDIV:
            begin
                ar_a = AR_W'({el, 16'h0000});
                ar_d = DV_W'(dur);
            end
            SRC_TM1:
            begin
                ar_a = AR_W'(cur_reg.b);
                ar_b = MB_W'(p_inv);
            end
            SRC_TM2:
            begin
                ar_a = AR_W'(nxt_reg.b);
                ar_b = MB_W'(p_reg);
            end
            SRC_BASE:
            begin
                ar_a = AR_W'(base_reg);
                ar_b = MB_W'(base_len);
            end
            SRC_CONST:
            begin
                ar_a = ar_res >> CONST_PRESHIFT;
                ar_b = RECIP_15;
            end
            SRC_RDVS:
            begin
                ar_a = RAMP_SCALE;
                ar_b = MB_W'(dur);
            end
            SRC_CSEG:
            begin
                ar_a = AR_W'(cur_reg.b);
                ar_b = MB_W'(el);
            end
            SRC_R1:
            begin
                ar_a = AR_W'(cur_reg.b);
                ar_b = dur2_el;
            end
            SRC_R2:
            begin
                ar_a = AR_W'(nxt_reg.b);
                ar_b = MB_W'(el);
            end
            SRC_R3:
            begin
                ar_a = AR_W'(p1_sum);
                ar_b = MB_W'(el);
            end
            SRC_RDIV:
            begin
                ar_a = ar_res;
                ar_d = dvs_reg;
            end
            default:
            begin
                ar_a = '0;
            end
        endcase
    end

    tmb_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.ar_start),
        .op    (ar_op),
        .a     (ar_a),
        .b     (ar_b),
        .d     (ar_d),
        .busy  (ar_busy),
        .res   (ar_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            has_next_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_TEMPO:  base_reg  <= cfg_data;
                    CFG_ENTRY_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default:         base_reg  <= base_reg;
                endcase
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_plus;
            if (cmd.has_next_set)
                has_next_reg <= 1'b1;
            else if (cmd.has_next_clr)
                has_next_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
            q_reg <= in_query;
        if (cmd.cur_from_rd)
            cur_reg <= rd_reg;
        else if (cmd.cur_from_nxt)
            cur_reg <= nxt_reg;
        if (cmd.nxt_from_rd)
            nxt_reg <= rd_reg;
        if (cmd.p_load)
            p_reg <= ar_res[PROG_W-1:0];
        if (cmd.p1_load)
            p1_reg <= ar_res[P1_W-1:0];
        if (cmd.dvs_load)
            dvs_reg <= ar_res[DV_W-1:0];
        if (cmd.ar_start)
            recip_reg <= (cmd.ar_src == SRC_CONST);
        case (cmd.tempo_sel)
            TSEL_BASE: tempo_reg <= base_reg;
            TSEL_CUR:  tempo_reg <= cur_reg.b;
            TSEL_RAMP: tempo_reg <= p1_sum[16 +: BPM_W];
            default:   tempo_reg <= tempo_reg;
        endcase
        if (cmd.beats_clr)
            beats_reg <= '0;
        else if (cmd.beats_add)
            beats_reg <= beats_sat ? BEATS_MAX : beats_sum[BEATS_W-1:0];
        if (cmd.out_load)
        begin
            out_tempo_reg <= tempo_reg;
            out_beats_reg <= beats_reg;
        end
    end

    assign st.q_req        = s_tvalid && s_tuser;
    assign st.n_zero       = (n == '0);
    assign st.q_lt_rd      = q_reg < rd_reg.t;
    assign st.rd_le_q      = rd_reg.t <= q_reg;
    assign st.has_more     = {1'b0, idx_plus} < {1'b0, n};
    assign st.has_next     = has_next_reg;
    assign st.cur_ramp     = cur_reg.r;
    assign st.q_le_cur     = q_reg <= cur_reg.t;
    assign st.end_le_cur   = end_t <= cur_reg.t;
    assign st.q_le_seg_end = q_reg <= seg_end;
    assign st.ar_busy      = ar_busy;
    assign st.out_busy     = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_beats_reg, out_tempo_reg};

endmodule
`default_nettype wire

FILE: rtl/tmb_ctrl.sv
`default_nettype none
module tmb_ctrl
    import tmb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tmb_status_t st,
    output tmb_cmd_t         cmd
);

    tmb_state_t state_reg, state_next;
    logic       base_seg_reg, base_seg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            base_seg_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_seg_reg <= base_seg_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        base_seg_next = base_seg_reg;
        case (state_reg)
            ST_IDLE:    if (st.q_req) state_next = ST_T_START;
            ST_T_START: state_next = st.n_zero ? ST_B_START : ST_T_FIRST;
            ST_T_FIRST: state_next = st.q_lt_rd ? ST_B_START : ST_T_SEG;
            ST_T_SEG:   state_next = st.has_more ? ST_T_NXT : ST_T_PICK;
            ST_T_NXT:   state_next = st.rd_le_q ? ST_T_SEG : ST_T_PICK;
            ST_T_PICK:  state_next = (st.cur_ramp && st.has_next) ? ST_T_DIV : ST_B_START;
            ST_T_DIV:   if (!st.ar_busy) state_next = ST_T_M1;
            ST_T_M1:    if (!st.ar_busy) state_next = ST_T_M2;
            ST_T_M2:    if (!st.ar_busy) state_next = ST_B_START;
            ST_B_START: state_next = ST_B_BASE;
            ST_B_BASE:
            begin
                base_seg_next = 1'b1;
                state_next    = ST_B_CM;
            end
            ST_B_CM:    if (!st.ar_busy) state_next = ST_B_CD;
            ST_B_CD:
            begin
                if (!st.ar_busy)
                begin
                    if (base_seg_reg)
                        state_next = (st.n_zero || st.q_le_cur) ? ST_FIN : ST_B_SEG;
                    else
                        state_next = st.q_le_seg_end ? ST_FIN : ST_B_ADV;
                end
            end
            ST_B_SEG:   state_next = st.has_more ? ST_B_NXT : ST_B_EVAL;
            ST_B_NXT:   state_next = ST_B_EVAL;
            ST_B_EVAL:
            begin
                base_seg_next = 1'b0;
                if (st.q_le_cur)
                    state_next = ST_FIN;
                else if (st.end_le_cur)
                    state_next = ST_B_ADV;
                else if (st.cur_ramp && st.has_next)
                    state_next = ST_B_RD;
                else
                    state_next = ST_B_CM;
            end
            ST_B_RD:    if (!st.ar_busy) state_next = ST_B_R1;
            ST_B_R1:    if (!st.ar_busy) state_next = ST_B_R2;
            ST_B_R2:    if (!st.ar_busy) state_next = ST_B_R3;
            ST_B_R3:    if (!st.ar_busy) state_next = ST_B_CD;
            ST_B_ADV:   state_next = st.has_more ? ST_B_SEG : ST_FIN;
            ST_FIN:     if (!st.out_busy) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.tempo_sel = TSEL_NONE;
        cmd.ar_src    = SRC_TDIV;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.q_load   = st.q_req;
            end
            ST_T_START:
            begin
                cmd.idx_clr = 1'b1;
                cmd.rd_en   = 1'b1;
                if (st.n_zero)
                    cmd.tempo_sel = TSEL_BASE;
            end
            ST_T_FIRST:
            begin
                cmd.cur_from_rd = 1'b1;
                if (st.q_lt_rd)
                    cmd.tempo_sel = TSEL_BASE;
            end
            ST_T_SEG:
            begin
                if (st.has_more)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
                else
                    cmd.has_next_clr = 1'b1;
            end
            ST_T_NXT:
            begin
                cmd.nxt_from_rd = 1'b1;
                // advance while the next change has already started
                if (st.rd_le_q)
                begin
                    cmd.idx_inc     = 1'b1;
                    cmd.cur_from_rd = 1'b1;
                end
                else
                    cmd.has_next_set = 1'b1;
            end
            ST_T_PICK:
            begin
                if (st.cur_ramp && st.has_next)
                begin
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_TDIV;
                end
                else
                    cmd.tempo_sel = TSEL_CUR;
            end
            ST_T_DIV:
            begin
                if (!st.ar_busy)
                begin
                    cmd.p_load   = 1'b1;
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_TM1;
                end
            end
            ST_T_M1:
            begin
                if (!st.ar_busy)
                begin
                    cmd.p1_load  = 1'b1;
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_TM2;
                end
            end
            ST_T_M2:
            begin
                if (!st.ar_busy)
                    cmd.tempo_sel = TSEL_RAMP;
            end
            ST_B_START:
            begin
                cmd.idx_clr   = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.beats_clr = 1'b1;
            end
            ST_B_BASE:
            begin
                cmd.cur_from_rd = 1'b1;
                cmd.ar_start    = 1'b1;
                cmd.ar_src      = SRC_BASE;
            end
            ST_B_CM:
            begin
                if (!st.ar_busy)
                begin
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_CONST;
                end
            end
            ST_B_CD:
            begin
                if (!st.ar_busy)
                    cmd.beats_add = 1'b1;
            end
            ST_B_SEG:
            begin
                if (st.has_more)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
                else
                    cmd.has_next_clr = 1'b1;
            end
            ST_B_NXT:
            begin
                cmd.nxt_from_rd  = 1'b1;
                cmd.has_next_set = 1'b1;
            end
            ST_B_EVAL:
            begin
                if (!st.q_le_cur && !st.end_le_cur)
                begin
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = (st.cur_ramp && st.has_next) ? SRC_RDVS : SRC_CSEG;
                end
            end
            ST_B_RD:
            begin
                if (!st.ar_busy)
                begin
                    cmd.dvs_load = 1'b1;
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_R1;
                end
            end
            ST_B_R1:
            begin
                if (!st.ar_busy)
                begin
                    cmd.p1_load  = 1'b1;
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_R2;
                end
            end
            ST_B_R2:
            begin
                if (!st.ar_busy)
                begin
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_R3;
                end
            end
            ST_B_R3:
            begin
                if (!st.ar_busy)
                begin
                    cmd.ar_start = 1'b1;
                    cmd.ar_src   = SRC_RDIV;
                end
            end
            ST_B_ADV:
            begin
                if (st.has_more)
                begin
                    cmd.idx_inc      = 1'b1;
                    cmd.cur_from_nxt = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.out_load = !st.out_busy;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: bench/tempo_map_time_to_beats_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module tempo_map_time_to_beats_top_test;
    import tmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_ITEMS    = 62;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam logic [BPM_W-1:0]  BPM_LO   = 25'd1310720;
    localparam logic [BPM_W-1:0]  BPM_HI   = 25'd26214400;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;
    localparam logic [TIME_W-1:0] ONE_SEC  = 40'h10000;

    typedef struct {
        logic              kind;
        logic [3:0]        slot;
        logic [TIME_W-1:0] at;
        logic [BPM_W-1:0]  bpm;
        logic              ramp;
        logic [TIME_W-1:0] when;
    } tempo_item_t;

    typedef struct {
        logic [BPM_W-1:0]   tempo;
        logic [BEATS_W-1:0] beats;
    } tempo_result_t;

    class tempo_scoreboard;
        logic [BPM_W-1:0]  base_bpm;
        logic [COUNT_W-1:0] live_count;
        logic [TIME_W-1:0] t_tab[16];
        logic [BPM_W-1:0]  b_tab[16];
        logic              r_tab[16];
        tempo_result_t     pending[$];
        int                mismatches;

        function new();
            base_bpm   = BASE_RESET;
            live_count = '0;
            mismatches = 0;
            for (int i = 0; i < 16; i++)
            begin
                t_tab[i] = 0;
                b_tab[i] = 0;
                r_tab[i] = 0;
            end
        endfunction

        function void write_reg(logic idx, logic [BPM_W-1:0] v);
            if (idx == CFG_BASE_TEMPO)
                base_bpm = v;
            else
                live_count = v[COUNT_W-1:0];
        endfunction

        function int live_entries();
            return (live_count > 16) ? 16 : int'(live_count);
        endfunction

        function logic [BEATS_W-1:0] sat_sum(logic [BEATS_W-1:0] acc, logic [127:0] v);
            logic [127:0] s;
            s = {80'b0, acc} + v;
            if (v > {80'b0, BEATS_MAX} || s > {80'b0, BEATS_MAX})
                return BEATS_MAX;
            return s[BEATS_W-1:0];
        endfunction

        function logic [127:0] flat_beats(logic [127:0] bpm, logic [127:0] el);
            return (bpm * el) / 128'd3932160;
        endfunction

        function logic [127:0] ramp_beats(logic [127:0] a, logic [127:0] b,
                                          logic [127:0] el, logic [127:0] dur);
            logic [127:0] inner;
            if (dur == 0)
                return 0;
            inner = a * (2 * dur - el) + b * el;
            return (inner * el) / (dur * 128'd7864320);
        endfunction

        function logic [BPM_W-1:0] tempo_at(logic [TIME_W-1:0] pos);
            int n;
            int i;
            logic [63:0] ta, tb, el, dur, p, mix;
            n = live_entries();
            i = 0;
            if (n == 0 || pos < t_tab[0])
                return base_bpm;
            while (i + 1 < n && t_tab[i+1] <= pos)
                i++;
            if (!r_tab[i] || i + 1 >= n)
                return b_tab[i];
            ta = t_tab[i];
            tb = t_tab[i+1];
            if (tb <= ta)
                return b_tab[i+1];
            dur = tb - ta;
            el  = pos - ta;
            if (el > dur)
                el = dur;
            p   = (el << 16) / dur;
            mix = (64'(b_tab[i]) * (65536 - p) + 64'(b_tab[i+1]) * p) >> 16;
            return mix[BPM_W-1:0];
        endfunction

        function logic [BEATS_W-1:0] beats_at(logic [TIME_W-1:0] target);
            int n;
            logic [BEATS_W-1:0] acc;
            logic [TIME_W-1:0] t0, ti, seg_end, stop;
            logic has_next;
            n   = live_entries();
            acc = 0;
            if (n == 0)
                return sat_sum(0, flat_beats(base_bpm, target));
            t0 = t_tab[0];
            if (t0 > 0)
            begin
                acc = sat_sum(acc, flat_beats(base_bpm, (target < t0) ? target : t0));
                if (target <= t0)
                    return acc;
            end
            for (int i = 0; i < n; i++)
            begin
                ti       = t_tab[i];
                has_next = (i + 1 < n);
                seg_end  = has_next ? t_tab[i+1] : target;
                stop     = (target < seg_end) ? target : seg_end;
                if (target <= ti)
                    return acc;
                if (stop <= ti)
                    continue;
                if (r_tab[i] && has_next)
                    acc = sat_sum(acc, ramp_beats(b_tab[i], b_tab[i+1], stop - ti,
                                                  seg_end - ti));
                else
                    acc = sat_sum(acc, flat_beats(b_tab[i], stop - ti));
                if (target <= seg_end)
                    return acc;
            end
            return acc;
        endfunction

        function void note_input(tempo_item_t it);
            tempo_result_t r;
            if (it.kind == KIND_LOAD)
            begin
                t_tab[it.slot] = it.at;
                b_tab[it.slot] = it.bpm;
                r_tab[it.slot] = it.ramp;
            end
            else
            begin
                r.tempo = tempo_at(it.when);
                r.beats = beats_at(it.when);
                pending = {pending, r};
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            tempo_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tempo %0d beats %0d",
                             data[24:0], data[72:25]);
                return;
            end
            want = pending.pop_front();
            if (data[24:0] !== want.tempo || data[72:25] !== want.beats)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: tempo exp %0d got %0d, beats exp %0d got %0d",
                             want.tempo, data[24:0], want.beats, data[72:25]);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we;
    logic cfg_index;
    logic [BPM_W-1:0] cfg_data;

    tempo_scoreboard tempo_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    tempo_map_time_to_beats_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: stall at random, check each result beat
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tempo_sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(tempo_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b0, it.when, it.ramp, it.bpm, it.at, it.slot};
        do
            @(posedge clk);
        while (!s_tready);
        tempo_sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [BPM_W-1:0] v);
        s_tvalid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        tempo_sb.write_reg(idx, v);
        @(negedge clk);
    endtask

    // Drop valid, hold until every query is answered, then let trailing loads settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tempo_sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_full_time();
        return {8'($urandom_range(255)), 32'($urandom())};
    endfunction

    function automatic logic [BPM_W-1:0] rand_bpm();
        case ($urandom_range(9))
            0: return BPM_LO;
            1: return BPM_HI;
            default: return 25'($urandom_range(BPM_HI, BPM_LO));
        endcase
    endfunction

    function automatic tempo_item_t load_item(int slot, logic [TIME_W-1:0] at,
                                              logic [BPM_W-1:0] bpm, logic ramp);
        tempo_item_t it;
        it.kind = KIND_LOAD;
        it.slot = 4'(slot);
        it.at   = at;
        it.bpm  = bpm;
        it.ramp = ramp;
        it.when = rand_full_time();
        return it;
    endfunction

    function automatic tempo_item_t query_item(logic [TIME_W-1:0] when);
        tempo_item_t it;
        it.kind = KIND_QUERY;
        it.slot = 4'($urandom_range(15));
        it.at   = rand_full_time();
        it.bpm  = rand_bpm();
        it.ramp = 1'($urandom_range(1));
        it.when = when;
        return it;
    endfunction

    initial
    begin
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] marks[16];
        logic [BPM_W-1:0]  base_v;
        int n;
        int sent;
        int pick;

        tempo_sb       = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_LOAD;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BASE_TEMPO;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table: base tempo everywhere
        send_item(query_item(0));
        send_item(query_item(TIME_TOP));
        // Sorted table with a zero-length segment at slots 1..2, ramps on all slots but 2, 5, 8, 11 and 14
        for (int i = 0; i < 16; i++)
            send_item(load_item(i, (i == 15) ? TIME_TOP : ((i == 2) ? 2 : i + 1) * ONE_SEC,
                                (i % 2) ? BPM_HI : BPM_LO, (i % 3) != 2));
        drain();
        write_reg(CFG_ENTRY_COUNT, 25'd4);
        send_item(query_item(ONE_SEC / 2));
        send_item(query_item(ONE_SEC));
        send_item(query_item(ONE_SEC + ONE_SEC / 3));
        send_item(query_item(2 * ONE_SEC));
        send_item(query_item(10 * ONE_SEC));
        send_item(query_item(TIME_TOP));
        drain();
        write_reg(CFG_ENTRY_COUNT, 25'd16);
        send_item(query_item(TIME_TOP));
        send_item(query_item(14 * ONE_SEC + 77));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: begin n = 0;  base_v = BPM_LO; end
                4: begin n = 16; base_v = BPM_HI; end
                default: begin n = $urandom_range(5, 1); base_v = rand_bpm(); end
            endcase
            write_reg(CFG_BASE_TEMPO, base_v);
            write_reg(CFG_ENTRY_COUNT, BPM_W'(n));
            sent = 0;

            // Well-formed table: increasing times, some repeats
            span  = ($urandom_range(9) == 0) ? 40'h40_0000_0000 : 40'(20 * ONE_SEC);
            stamp = ($urandom_range(3) == 0) ? '0 : 40'($urandom_range(5 * 65536));
            for (int i = 0; i < n; i++)
            begin
                marks[i] = stamp;
                send_item(load_item(i, stamp, rand_bpm(), 1'($urandom_range(1))));
                sent++;
                if ($urandom_range(7) != 0)
                    stamp = stamp + 40'($urandom_range(span[39:8] > 0 ? 1 << 24 : 1, 1))
                            * ((span > 40'(20 * ONE_SEC)) ? 40'h10000 : 40'd1)
                            + 40'($urandom_range(65535));
            end
            if (n == 0)
                marks[0] = ONE_SEC;

            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    send_item(load_item($urandom_range(15), rand_full_time(), rand_bpm(),
                                        1'($urandom_range(1))));
                else if (pick < 25)
                    send_item(query_item(marks[$urandom_range(n > 0 ? n - 1 : 0)]));
                else if (pick < 32)
                    send_item(query_item(rand_full_time()));
                else
                    send_item(query_item(40'($urandom_range(32'(stamp[39:8]) + 4096)) * 256
                                         + 40'($urandom_range(255))));
                sent++;
            end
            drain();
        end

        // Put both registers back to their extremes once more
        write_reg(CFG_BASE_TEMPO, BPM_HI);
        write_reg(CFG_ENTRY_COUNT, 25'd16);
        send_item(query_item(rand_full_time()));
        drain();

        if (tempo_sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
